### rtl/boid_pkg.sv
// ----------------------------------------------------------------------------
// boid_pkg
// Shared types, codes and helpers for the BER object identifier decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package boid_pkg;

    // Longest long-form length field accepted, in bytes
    localparam int C_LENGTH_BYTES = 4;

    // Result kinds
    localparam logic [1:0] KIND_TAG  = 2'd0;
    localparam logic [1:0] KIND_COMP = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;
    localparam logic [1:0] KIND_ERR  = 2'd3;

    // Status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_INDEFINITE = 3'd1;
    localparam logic [2:0] ST_LEN_LONG   = 3'd2;
    localparam logic [2:0] ST_OVERFLOW   = 3'd3;
    localparam logic [2:0] ST_SUBID_BIG  = 3'd4;
    localparam logic [2:0] ST_TRUNCATED  = 3'd5;
    localparam logic [2:0] ST_MALFORMED  = 3'd6;

    // Configuration register indexes
    localparam logic CFG_CAPACITY = 1'b0;
    localparam logic CFG_LARGEST  = 1'b1;

    // Configuration reset values
    localparam logic [7:0]  C_CAPACITY_RST = 8'd128;
    localparam logic [31:0] C_LARGEST_RST  = 32'hFFFF_FFFF;

    // First subid split: x / 40 for x < 440 is (x * 205) >> 13
    localparam logic [5:0] C_DIVISOR     = 6'd40;
    localparam logic [7:0] C_RECIP       = 8'd205;
    localparam int         C_RECIP_SHIFT = 13;

    // Decoder phase, one-hot
    typedef enum logic [4:0] {
        PH_IDLE      = 5'b00001,
        PH_LEN_FIRST = 5'b00010,
        PH_LEN_LONG  = 5'b00100,
        PH_CONTENT   = 5'b01000,
        PH_SKIP      = 5'b10000
    } t_phase;

    // One result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] value;
        logic [7:0]  position;
        logic [2:0]  status;
        logic        last;
    } t_result;

    function automatic t_result mk_result(logic [1:0] kind, logic [31:0] value,
                                          logic [7:0] position, logic [2:0] status,
                                          logic last);
        t_result r;
        r.kind     = kind;
        r.value    = value;
        r.position = position;
        r.status   = status;
        r.last     = last;
        return r;
    endfunction

endpackage

### rtl/ber_oid_decoder.sv
// ----------------------------------------------------------------------------
// ber_oid_decoder
// BER object identifier decoder, one encoded byte per input transfer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one byte per transfer;
//   i_object_start marks the tag byte and then i_bytes_available is latched.
//   Output channel (o_out_valid / i_out_stall) carries one result per
//   transfer: tag, component, end of object or error, with status codes.
//   Config port writes component_capacity (index 0) and largest_subid (index 1).
//   Write them only while the decoder is idle; the block does not enforce it.
// Output timing: results of a byte are presented the cycle after its transfer.
// Throughput: one byte per cycle while each byte yields at most one result and
//   the receiver does not stall. A byte that yields more results (at most
//   three: the two parts of the first subid plus end of object) holds the
//   input while the three-entry result queue drains them, one per transfer.
// Stall: while the receiver stalls with a result pending, results hold still
//   and the input is stalled as well; a new byte is taken only when the
//   queue is empty or its last result leaves in the same cycle.
// Reset: synchronous, active low; clears the decoder to waiting for a tag,
//   empties the result queue and restores both config registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ber_oid_decoder
    import boid_pkg::*;
#(
    parameter int LENGTH_BYTES = C_LENGTH_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_object_start,
    input  logic [15:0] i_bytes_available,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [31:0] o_value,
    output logic [7:0]  o_position,
    output logic [2:0]  o_status,
    output logic        o_last_of_object
);

    localparam int LBW = $clog2(LENGTH_BYTES + 1);

    // config registers
    logic [7:0]  r_cap;
    logic [31:0] r_largest;

    // decoder state
    t_phase          r_phase,   n_phase;
    logic [LBW-1:0]  r_lbl,     n_lbl;
    logic [3:0]      r_hc,      n_hc;
    logic [31:0]     r_ol,      n_ol;
    logic [15:0]     r_cl,      n_cl;
    logic [15:0]     r_avail,   n_avail;
    logic [31:0]     r_acc,     n_acc;
    logic [5:0]      r_rem,     n_rem;
    logic [7:0]      r_qlo,     n_qlo;
    logic [7:0]      r_count,   n_count;
    logic            r_first,   n_first;

    // result queue
    t_result         r_buf [3];
    logic [1:0]      r_cnt;
    t_result         res [3];
    logic [1:0]      res_n;

    logic in_xfer, out_xfer, can_take;

    // datapath helpers
    logic [3:0]  hc_inc;
    logic [31:0] ol_long;
    logic [31:0] hd_ol;
    logic        hd_over;
    logic [31:0] acc_new;
    logic        acc_ovf;
    logic [15:0] cl_dec;
    logic [8:0]  u;
    logic [16:0] prod;
    logic [3:0]  d;
    logic [8:0]  u_rem;
    logic [5:0]  rem_new;
    logic [7:0]  qlo_new;
    logic [7:0]  count_inc;
    logic [7:0]  cap_eff;
    logic [7:0]  cnt_after;
    logic [6:0]  len_cnt;
    t_result     end_rec;

    // handshakes
    assign out_xfer   = (r_cnt != 2'd0) && !i_out_stall;
    assign can_take   = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && out_xfer);
    assign o_in_stall = !can_take;
    assign in_xfer    = i_in_valid && can_take;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap     <= C_CAPACITY_RST;
            r_largest <= C_LARGEST_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CAPACITY: r_cap     <= i_cfg_data[7:0];
                CFG_LARGEST:  r_largest <= i_cfg_data;
                default:      r_cap     <= r_cap;
            endcase
        end
    end

    // header arithmetic
    assign hc_inc  = r_hc + 4'd1;
    assign ol_long = (r_ol > 32'h00FF_FFFF) ? 32'hFFFF_FFFF : {r_ol[23:0], i_data_byte};
    assign hd_ol   = (r_phase == PH_LEN_FIRST) ? {24'd0, i_data_byte} : ol_long;
    assign hd_over = ({1'b0, hd_ol} + {29'd0, hc_inc}) > {17'd0, r_avail};
    assign len_cnt = i_data_byte[6:0];

    // content arithmetic; quotient low byte and remainder by 40 tracked per byte
    assign acc_ovf   = (r_acc[31:25] != 7'd0);
    assign acc_new   = {r_acc[24:0], i_data_byte[6:0]};
    assign cl_dec    = r_cl - 16'd1;
    assign u         = {r_rem, 3'b000} + {2'b00, i_data_byte[6:0]};
    assign prod      = {8'd0, u} * {9'd0, C_RECIP};
    assign d         = prod[16:C_RECIP_SHIFT];
    assign u_rem     = u - ({5'd0, d} * {3'd0, C_DIVISOR});
    assign rem_new   = u_rem[5:0];
    assign qlo_new   = {r_qlo[0], 7'd0} + {2'b00, r_rem} + {1'b0, r_rem, 1'b0} + {4'd0, d};
    assign count_inc = r_count + 8'd1;
    assign cap_eff   = (r_cap < 8'd2) ? 8'd2 : r_cap;
    assign cnt_after = r_first ? 8'd2 : count_inc;
    assign end_rec   = mk_result(KIND_END, {24'd0, cnt_after}, 8'd0, ST_OK, 1'b1);

    // next state and results of one byte
    always_comb begin
        n_phase = r_phase;
        n_lbl   = r_lbl;
        n_hc    = r_hc;
        n_ol    = r_ol;
        n_cl    = r_cl;
        n_avail = r_avail;
        n_acc   = r_acc;
        n_rem   = r_rem;
        n_qlo   = r_qlo;
        n_count = r_count;
        n_first = r_first;
        res[0]  = '0;
        res[1]  = '0;
        res[2]  = '0;
        res_n   = 2'd0;

        if (i_object_start) begin
            n_avail = i_bytes_available;
            n_lbl   = '0;
            n_hc    = 4'd1;
            n_ol    = '0;
            n_cl    = '0;
            n_acc   = '0;
            n_rem   = '0;
            n_qlo   = '0;
            n_count = '0;
            n_first = 1'b1;
            n_phase = PH_LEN_FIRST;
            res[0]  = mk_result(KIND_TAG, {24'd0, i_data_byte}, 8'd0, ST_OK, 1'b0);
            res_n   = 2'd1;
        end else begin
            unique case (r_phase)
                PH_LEN_FIRST, PH_LEN_LONG: begin
                    n_hc = hc_inc;
                    if ((r_phase == PH_LEN_FIRST) && i_data_byte[7]) begin
                        // long form: count of length bytes
                        if (len_cnt == 7'd0) begin
                            n_phase = PH_IDLE;
                            res[0]  = mk_result(KIND_ERR, '0, '0, ST_INDEFINITE, 1'b1);
                            res_n   = 2'd1;
                        end else if ({25'd0, len_cnt} > LENGTH_BYTES) begin
                            n_phase = PH_IDLE;
                            res[0]  = mk_result(KIND_ERR, '0, '0, ST_LEN_LONG, 1'b1);
                            res_n   = 2'd1;
                        end else begin
                            n_lbl   = len_cnt[LBW-1:0];
                            n_ol    = '0;
                            n_phase = PH_LEN_LONG;
                        end
                    end else begin
                        n_ol  = hd_ol;
                        n_lbl = r_lbl - LBW'(1);
                        // header complete on short form or last length byte
                        if ((r_phase == PH_LEN_FIRST) || (r_lbl == LBW'(1))) begin
                            if (hd_over) begin
                                n_phase = PH_IDLE;
                                res[0]  = mk_result(KIND_ERR, '0, '0, ST_OVERFLOW, 1'b1);
                                res_n   = 2'd1;
                            end else if (hd_ol == 32'd0) begin
                                n_phase = PH_IDLE;
                                res[0]  = mk_result(KIND_ERR, '0, '0, ST_MALFORMED, 1'b1);
                                res_n   = 2'd1;
                            end else begin
                                n_cl    = hd_ol[15:0];
                                n_acc   = '0;
                                n_rem   = '0;
                                n_qlo   = '0;
                                n_count = '0;
                                n_first = 1'b1;
                                n_phase = PH_CONTENT;
                            end
                        end
                    end
                end
                PH_CONTENT: begin
                    if (acc_ovf) begin
                        n_phase = PH_IDLE;
                        res[0]  = mk_result(KIND_ERR, '0, '0, ST_SUBID_BIG, 1'b1);
                        res_n   = 2'd1;
                    end else begin
                        n_acc = acc_new;
                        n_rem = rem_new;
                        n_qlo = qlo_new;
                        n_cl  = cl_dec;
                        if (i_data_byte[7]) begin
                            // continuation byte; content must not end here
                            if (cl_dec == 16'd0) begin
                                n_phase = PH_IDLE;
                                res[0]  = mk_result(KIND_ERR, '0, '0, ST_MALFORMED, 1'b1);
                                res_n   = 2'd1;
                            end
                        end else if (acc_new > r_largest) begin
                            n_phase = PH_IDLE;
                            res[0]  = mk_result(KIND_ERR, '0, '0, ST_SUBID_BIG, 1'b1);
                            res_n   = 2'd1;
                        end else begin
                            // subid complete
                            if (r_first) begin
                                res[0] = mk_result(KIND_COMP, {24'd0, qlo_new}, 8'd0,
                                                   ST_OK, 1'b0);
                                res[1] = mk_result(KIND_COMP, {26'd0, rem_new}, 8'd1,
                                                   ST_OK, 1'b0);
                                res[2] = end_rec;
                                res_n  = 2'd2;
                            end else begin
                                res[0] = mk_result(KIND_COMP, acc_new, r_count, ST_OK, 1'b0);
                                res[1] = end_rec;
                                res_n  = 2'd1;
                            end
                            n_first = 1'b0;
                            n_count = cnt_after;
                            n_acc   = '0;
                            n_rem   = '0;
                            n_qlo   = '0;
                            if (cl_dec == 16'd0) begin
                                n_phase = PH_IDLE;
                                res_n   = res_n + 2'd1;
                            end else if ((cnt_after == 8'd0) || (cnt_after >= cap_eff)) begin
                                n_phase = PH_SKIP;
                            end
                        end
                    end
                end
                PH_SKIP: begin
                    n_cl = cl_dec;
                    if (cl_dec == 16'd0) begin
                        n_phase = PH_IDLE;
                        res[0]  = mk_result(KIND_END, {24'd0, r_count}, 8'd0,
                                            ST_TRUNCATED, 1'b1);
                        res_n   = 2'd1;
                    end
                end
                default: begin
                    // idle: bytes outside an object are dropped
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    // decoder state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_lbl   <= '0;
            r_hc    <= '0;
            r_ol    <= '0;
            r_cl    <= '0;
            r_avail <= '0;
            r_acc   <= '0;
            r_rem   <= '0;
            r_qlo   <= '0;
            r_count <= '0;
            r_first <= 1'b1;
        end else if (in_xfer) begin
            r_phase <= n_phase;
            r_lbl   <= n_lbl;
            r_hc    <= n_hc;
            r_ol    <= n_ol;
            r_cl    <= n_cl;
            r_avail <= n_avail;
            r_acc   <= n_acc;
            r_rem   <= n_rem;
            r_qlo   <= n_qlo;
            r_count <= n_count;
            r_first <= n_first;
        end
    end

    // result queue occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (in_xfer) begin
            r_cnt <= res_n;
        end else if (out_xfer) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    // result queue payload, head at entry 0
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_buf[0] <= res[0];
            r_buf[1] <= res[1];
            r_buf[2] <= res[2];
        end else if (out_xfer) begin
            r_buf[0] <= r_buf[1];
            r_buf[1] <= r_buf[2];
        end
    end

    assign o_out_valid      = (r_cnt != 2'd0);
    assign o_kind           = r_buf[0].kind;
    assign o_value          = r_buf[0].value;
    assign o_position       = r_buf[0].position;
    assign o_status         = r_buf[0].status;
    assign o_last_of_object = r_buf[0].last;

    // checks
    a_last_is_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_of_object) |-> (r_cnt == 2'd1))
        else $error("result after end of object in queue");

    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind == KIND_ERR)) |-> o_last_of_object)
        else $error("error result not marked last");

    a_stall_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt > 2'd1) |-> o_in_stall)
        else $error("input taken while several results pending");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem < C_DIVISOR)
        else $error("remainder by 40 out of range");

    a_count_after_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase == PH_CONTENT) && !r_first) |-> (r_count >= 8'd2))
        else $error("component count below two after first subid");

endmodule
